/* design/fpba_pkg.sv */
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared sizes, codes and control bundles of the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	localparam int OP_W   = 1;
	localparam int BLK_W  = 4;
	localparam int VAL_W  = 16;
	localparam int STAT_W = 2;
	localparam int POL_W  = 2;
	localparam int ACT_W  = 5;
	localparam int CFG_W  = 5;
	localparam int REGI_W = 1;
	localparam int LIM_W  = (CNT_W > ACT_W) ? CNT_W : ACT_W;

	localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
	localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

	localparam logic [STAT_W-1:0] STAT_LOADED  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ALLOC   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOALLOC = 2'd2;

	localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POL_W-1:0] POL_WORST = 2'd2;

	localparam logic [REGI_W-1:0] REG_FIT_POLICY    = 1'd0;
	localparam logic [REGI_W-1:0] REG_ACTIVE_BLOCKS = 1'd1;

	localparam logic [POL_W-1:0] POLICY_RESET = POL_FIRST;
	localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic                 we;
		logic [IDX_W-1:0]     addr;
		logic [SIZE_BITS-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic                 found;
		logic [SIZE_BITS-1:0] best;
		logic [SIZE_BITS-1:0] size;
	} scan_t;

	typedef struct packed {
		logic              valid;
		logic [STAT_W-1:0] status;
		logic [BLK_W-1:0]  blk;
		logic [VAL_W-1:0]  left;
	} res_t;

endpackage

/* design/fpba_cmd_if.sv */
// ----------------------------------------------------------------------------
// fpba_cmd_if
// Command channel: load or allocation request items.
// ----------------------------------------------------------------------------
interface fpba_cmd_if import fpba_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [BLK_W-1:0]  block_number;
	logic [VAL_W-1:0]  size_value;

	modport source (output valid, output opcode, output block_number, output size_value,
		input ready);
	modport sink (input valid, input opcode, input block_number, input size_value,
		output ready);

endinterface

/* design/fpba_rsp_if.sv */
// ----------------------------------------------------------------------------
// fpba_rsp_if
// Response channel: one result item per command item.
// ----------------------------------------------------------------------------
interface fpba_rsp_if import fpba_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [BLK_W-1:0]  chosen_block;
	logic [VAL_W-1:0]  space_left;

	modport source (output valid, output status, output chosen_block, output space_left,
		input ready);
	modport sink (input valid, input status, input chosen_block, input space_left,
		output ready);

endinterface

/* design/fpba_table.sv */
// ----------------------------------------------------------------------------
// fpba_table
// Free-space table: one write port, one combinational read port, cleared at reset.
// ----------------------------------------------------------------------------
module fpba_table import fpba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbl_wr_t              wr,
	input  logic [IDX_W-1:0]     rd_addr,
	output logic [SIZE_BITS-1:0] rd_data
);

	logic [SIZE_BITS-1:0] space_q [NUM_BLOCKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				space_q[i] <= '0;
			end
		end else if (wr.we) begin
			space_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = space_q[rd_addr];

endmodule

/* design/fpba_cmp.sv */
// ----------------------------------------------------------------------------
// fpba_cmp
// Shared compare unit: decides whether the scanned entry becomes the pick.
// ----------------------------------------------------------------------------
module fpba_cmp import fpba_pkg::*; (
	input  logic [SIZE_BITS-1:0] value,
	input  scan_t                scan,
	input  logic [POL_W-1:0]     policy,
	output logic                 take
);

	logic fits;
	logic better;

	assign fits = (value >= scan.size);

	always_comb begin
		case (policy)
			POL_BEST:  better = (value < scan.best);
			POL_WORST: better = (value > scan.best);
			default:   better = 1'b0;
		endcase
	end

	assign take = fits && (!scan.found || better);

endmodule

/* design/fpba_seq.sv */
// ----------------------------------------------------------------------------
// fpba_seq
// Sequencer: takes a command item, scans the table one entry per cycle for
// a request, writes back the chosen or loaded entry, hands over the result.
// ----------------------------------------------------------------------------
module fpba_seq import fpba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic [OP_W-1:0]      cmd_opcode,
	input  logic [BLK_W-1:0]     cmd_block,
	input  logic [VAL_W-1:0]     cmd_size,
	output logic                 cmd_ready,
	input  logic [CNT_W-1:0]     limit,
	input  logic [SIZE_BITS-1:0] rd_data,
	input  logic                 take,
	input  logic                 res_free,
	output logic [IDX_W-1:0]     rd_addr,
	output scan_t                scan,
	output tbl_wr_t              wr,
	output res_t                 res
);

	seq_state_t           state_q, state_d;
	logic [OP_W-1:0]      op_q;
	logic [BLK_W-1:0]     bn_q;
	logic [SIZE_BITS-1:0] sz_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;
	logic                 accept;
	logic                 scan_end;
	logic                 bn_in_range;
	logic [SIZE_BITS-1:0] diff;

	assign accept      = cmd_valid && cmd_ready;
	assign scan_end    = (cnt_q >= limit);
	assign bn_in_range = (int'(bn_q) < NUM_BLOCKS);
	assign diff        = best_q - sz_q;
	assign rd_addr     = cnt_q[IDX_W-1:0];
	assign scan        = '{found: found_q, best: best_q, size: sz_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (cmd_opcode == OP_REQUEST) ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		wr        = '{we: 1'b0, addr: '0, data: '0};
		res       = '{valid: 1'b0, status: STAT_NOALLOC, blk: '0, left: '0};
		case (state_q)
			S_IDLE: cmd_ready = 1'b1;
			S_DONE: begin
				res.valid = res_free;
				if (op_q == OP_LOAD) begin
					res.status = STAT_LOADED;
					res.blk    = bn_q;
					if (bn_in_range) begin
						res.left = VAL_W'(sz_q);
						wr.we    = res_free;
						wr.addr  = IDX_W'(bn_q);
						wr.data  = sz_q;
					end
				end else if (found_q) begin
					res.status = STAT_ALLOC;
					res.blk    = BLK_W'(pick_q);
					res.left   = VAL_W'(diff);
					wr.we      = res_free;
					wr.addr    = pick_q;
					wr.data    = diff;
				end
			end
			default: cmd_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else if (state_q == S_SCAN && !scan_end) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= cmd_opcode;
			bn_q <= cmd_block;
			sz_q <= SIZE_BITS'(cmd_size);
		end
		if (state_q == S_SCAN && !scan_end && take) begin
			pick_q <= cnt_q[IDX_W-1:0];
			best_q <= rd_data;
		end
	end

endmodule

/* design/fit_policy_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Free-space allocator with first, best and worst fit policies.
//
// cmd carries load items (write one block size) and request items (find a
// block with enough free space, subtract the size, report the index).
// rsp returns exactly one result item per command item, in order.
// wr_en/wr_index/wr_data write fit_policy (index 0) and active_blocks
// (index 1); the user must do so between items, the block does not check.
// A load goes from acceptance through the done state to the result
// register. A request scans min(active_blocks, 16) entries, one entry
// per cycle through a single shared comparator, then the chosen entry is
// written back. cmd.ready is high only while the sequencer is idle, so the
// next item can be accepted in the cycle after the result register loads.
// The result register lets the next item be accepted while a result waits;
// if rsp stalls, the sequencer holds its finished result until the
// register frees up.
// Reset clears the table to zero, sets first fit and 16 active blocks.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit import fpba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fpba_cmd_if.sink          cmd,
	fpba_rsp_if.source        rsp,
	input  logic              wr_en,
	input  logic [REGI_W-1:0] wr_index,
	input  logic [CFG_W-1:0]  wr_data
);

	logic [POL_W-1:0]     policy_q;
	logic [ACT_W-1:0]     active_q;
	logic [LIM_W-1:0]     active_ext;
	logic [CNT_W-1:0]     limit;
	logic [IDX_W-1:0]     rd_addr;
	logic [SIZE_BITS-1:0] rd_data;
	logic                 take;
	logic                 res_free;
	scan_t                scan;
	tbl_wr_t              wr;
	res_t                 res;
	logic                 rsp_valid_q;
	logic [STAT_W-1:0]    status_q;
	logic [BLK_W-1:0]     blk_q;
	logic [VAL_W-1:0]     left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_RESET;
			active_q <= ACTIVE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_FIT_POLICY:    policy_q <= wr_data[POL_W-1:0];
				REG_ACTIVE_BLOCKS: active_q <= wr_data[ACT_W-1:0];
				default:           ;
			endcase
		end
	end

	assign active_ext = LIM_W'(active_q);
	assign limit      = (active_ext > LIM_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
	                                                      : CNT_W'(active_ext);

	fpba_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd.valid),
		.cmd_opcode (cmd.opcode),
		.cmd_block  (cmd.block_number),
		.cmd_size   (cmd.size_value),
		.cmd_ready  (cmd.ready),
		.limit      (limit),
		.rd_data    (rd_data),
		.take       (take),
		.res_free   (res_free),
		.rd_addr    (rd_addr),
		.scan       (scan),
		.wr         (wr),
		.res        (res)
	);

	fpba_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fpba_cmp u_cmp (
		.value  (rd_data),
		.scan   (scan),
		.policy (policy_q),
		.take   (take)
	);

	assign res_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q <= res.status;
			blk_q    <= res.blk;
			left_q   <= res.left;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.chosen_block = blk_q;
	assign rsp.space_left   = left_q;

endmodule

/* test/fpba_alloc_checker.sv */
// ----------------------------------------------------------------------------
// fpba_alloc_checker
// Watches the command, response and register-write ports of the allocator.
// It keeps its own free-space table and policy settings, works out the
// grant for every accepted command item and compares each response item
// field by field, in order, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fpba_alloc_checker import fpba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fpba_cmd_if               cmd,
	fpba_rsp_if               rsp,
	input  logic              wr_en,
	input  logic [REGI_W-1:0] wr_index,
	input  logic [CFG_W-1:0]  wr_data,
	output int                mismatch_count,
	output int                grants_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BLK_W-1:0]  chosen_block;
		logic [VAL_W-1:0]  space_left;
	} grant_t;

	logic [SIZE_BITS-1:0] free_space [NUM_BLOCKS];
	logic [POL_W-1:0]     policy;
	logic [ACT_W-1:0]     active_count;
	grant_t               predicted_grants [$];

	function automatic grant_t predict_allocation(logic [OP_W-1:0] op,
			logic [BLK_W-1:0] blk, logic [VAL_W-1:0] size_in);
		grant_t               g;
		logic [SIZE_BITS-1:0] want;
		logic [SIZE_BITS-1:0] room;
		int                   scan_len;
		int                   pick;
		bit                   found;
		want  = SIZE_BITS'(size_in);
		found = 1'b0;
		pick  = 0;
		if (op == OP_LOAD) begin
			g.status       = STAT_LOADED;
			g.chosen_block = blk;
			g.space_left   = '0;
			if (int'(blk) < NUM_BLOCKS) begin
				free_space[blk] = want;
				g.space_left    = VAL_W'(want);
			end
			return g;
		end
		scan_len = (int'(active_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(active_count);
		for (int j = 0; j < scan_len; j++) begin
			room = free_space[j];
			if (room < want)
				continue;
			if (!found) begin
				found = 1'b1;
				pick  = j;
				if (policy != POL_BEST && policy != POL_WORST)
					break;
			end else if (policy == POL_BEST) begin
				if (room < free_space[pick])
					pick = j;
			end else if (policy == POL_WORST) begin
				if (room > free_space[pick])
					pick = j;
			end
		end
		if (!found) begin
			g.status       = STAT_NOALLOC;
			g.chosen_block = '0;
			g.space_left   = '0;
			return g;
		end
		free_space[pick] = free_space[pick] - want;
		g.status         = STAT_ALLOC;
		g.chosen_block   = BLK_W'(pick);
		g.space_left     = VAL_W'(free_space[pick]);
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t exp_g;
		if (!arst_n) begin
			for (int i = 0; i < NUM_BLOCKS; i++)
				free_space[i] = '0;
			policy       = POLICY_RESET;
			active_count = ACTIVE_RESET;
			predicted_grants.delete();
			mismatch_count = 0;
			grants_pending = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_FIT_POLICY:    policy = wr_data[POL_W-1:0];
					REG_ACTIVE_BLOCKS: active_count = wr_data[ACT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				predicted_grants.push_back(predict_allocation(cmd.opcode,
					cmd.block_number, cmd.size_value));
			if (rsp.valid && rsp.ready) begin
				if (predicted_grants.size() == 0) begin
					$error("result item with no prediction: status %0d block %0d left %0d",
						rsp.status, rsp.chosen_block, rsp.space_left);
					mismatch_count++;
				end else begin
					exp_g = predicted_grants.pop_front();
					if (rsp.status !== exp_g.status) begin
						$error("status: expected %0d, got %0d", exp_g.status, rsp.status);
						mismatch_count++;
					end
					if (rsp.chosen_block !== exp_g.chosen_block) begin
						$error("chosen_block: expected %0d, got %0d",
							exp_g.chosen_block, rsp.chosen_block);
						mismatch_count++;
					end
					if (rsp.space_left !== exp_g.space_left) begin
						$error("space_left: expected %0d, got %0d",
							exp_g.space_left, rsp.space_left);
						mismatch_count++;
					end
				end
			end
			grants_pending = predicted_grants.size();
		end
	end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the fit-policy block allocator. A directed run
// covers size extremes, every policy including the unused code, zero and
// oversized active counts and zero-size requests; random phases then mix
// loads and requests under changing settings, with random gaps on both
// channels and one long response stall that backs up the command side.
// ----------------------------------------------------------------------------
module testbench;
	import fpba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [POL_W-1:0] POL_UNUSED = 2'd3;
	localparam int LONG_HOLD = 400;
	localparam int NUM_PHASES = 8;

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic [REGI_W-1:0] wr_index;
	logic [CFG_W-1:0]  wr_data;
	int                mismatch_count;
	int                grants_pending;
	bit                long_hold_req = 1'b0;

	fpba_cmd_if cmd ();
	fpba_rsp_if rsp ();

	fit_policy_block_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rsp      (rsp),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	fpba_alloc_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.rsp            (rsp),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.mismatch_count (mismatch_count),
		.grants_pending (grants_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [VAL_W-1:0] pick_block_size();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return VAL_W'($urandom_range(0, 16'hFFFF));
			default: return VAL_W'($urandom_range(1, 2000));
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_request_size();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return '1;
			2, 3:    return VAL_W'($urandom_range(0, 16'hFFFF));
			default: return VAL_W'($urandom_range(1, 600));
		endcase
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk,
			input logic [VAL_W-1:0] size_in, input bit no_gap = 1'b0);
		int gap;
		gap = no_gap ? 0 : gap_len();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid        <= 1'b1;
		cmd.opcode       <= op;
		cmd.block_number <= blk;
		cmd.size_value   <= size_in;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (grants_pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [REGI_W-1:0] idx, input logic [CFG_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random_item(input bit no_gap);
		if ($urandom_range(0, 99) < 35)
			send_item(OP_LOAD, BLK_W'($urandom_range(0, 15)), pick_block_size(), no_gap);
		else
			send_item(OP_REQUEST, BLK_W'($urandom_range(0, 15)), pick_request_size(), no_gap);
	endtask

	initial begin : rsp_sink
		int run;
		int stall;
		bit hold_done;
		hold_done = 1'b0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
			repeat (run) @(posedge clk);
			stall = gap_len();
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [POL_W-1:0] phase_policy [NUM_PHASES];
		logic [ACT_W-1:0] phase_active [NUM_PHASES];
		int               phase_items  [NUM_PHASES];
		phase_policy = '{POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED,
			POL_BEST, POL_WORST, POL_FIRST, POL_BEST};
		phase_active = '{5'd16, 5'd5, 5'd1, 5'd16, 5'd31, 5'd12, 5'd0, 5'd16};
		phase_items  = '{60, 60, 60, 60, 60, 60, 10, 60};

		arst_n           <= 1'b0;
		cmd.valid        <= 1'b0;
		cmd.opcode       <= OP_LOAD;
		cmd.block_number <= '0;
		cmd.size_value   <= '0;
		wr_en            <= 1'b0;
		wr_index         <= REG_FIT_POLICY;
		wr_data          <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_LOAD, 4'd0, 16'hFFFF);
		send_item(OP_LOAD, 4'd15, 16'h0000);
		send_item(OP_LOAD, 4'd1, 16'd100);
		send_item(OP_LOAD, 4'd2, 16'd50);
		send_item(OP_LOAD, 4'd3, 16'd300);
		send_item(OP_LOAD, 4'd4, 16'h5555);
		send_item(OP_LOAD, 4'd6, 16'hAAAA);
		send_item(OP_REQUEST, 4'd9, 16'h0000);
		send_item(OP_REQUEST, 4'd0, 16'hFFFF);
		send_item(OP_REQUEST, 4'd15, 16'd60);
		send_item(OP_REQUEST, 4'd0, 16'hFFFF);
		drain();
		write_reg(REG_FIT_POLICY, CFG_W'(POL_BEST));
		send_item(OP_REQUEST, 4'd0, 16'd45);
		send_item(OP_REQUEST, 4'd0, 16'd40);
		drain();
		write_reg(REG_FIT_POLICY, CFG_W'(POL_WORST));
		send_item(OP_REQUEST, 4'd0, 16'd10);
		drain();
		write_reg(REG_FIT_POLICY, CFG_W'(POL_UNUSED));
		send_item(OP_REQUEST, 4'd0, 16'd20);
		drain();
		write_reg(REG_ACTIVE_BLOCKS, 5'd0);
		send_item(OP_REQUEST, 4'd0, 16'h0000);
		drain();
		write_reg(REG_ACTIVE_BLOCKS, 5'd31);
		write_reg(REG_FIT_POLICY, CFG_W'(POL_BEST));
		send_item(OP_LOAD, 4'd15, 16'd7);
		send_item(OP_REQUEST, 4'd0, 16'd7);
		drain();
		write_reg(REG_ACTIVE_BLOCKS, 5'd1);
		write_reg(REG_FIT_POLICY, CFG_W'(POL_FIRST));
		send_item(OP_REQUEST, 4'd0, 16'h0000);
		send_item(OP_REQUEST, 4'd0, 16'h0001);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_reg(REG_FIT_POLICY, CFG_W'(phase_policy[p]));
			write_reg(REG_ACTIVE_BLOCKS, CFG_W'(phase_active[p]));
			for (int k = 0; k < phase_items[p]; k++) begin
				if (p == 2 && k == 10)
					long_hold_req = 1'b1;
				send_random_item(p == 5 || (p == 2 && k >= 10 && k < 40));
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
